// ===== src/oled_i2c_pkg.sv =====
package oled_i2c_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SLAVE_ADDRESS = 2'd0,
        CFG_COMMAND_CTRL  = 2'd1,
        CFG_DATA_CTRL     = 2'd2,
        CFG_ACK_TIMEOUT   = 2'd3
    } cfg_index_t;

    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h78;
    localparam logic [7:0] COMMAND_CTRL_RESET  = 8'h00;
    localparam logic [7:0] DATA_CTRL_RESET     = 8'h40;
    localparam logic [7:0] ACK_TIMEOUT_RESET   = 8'd250;

    localparam logic [1:0] BYTE_ADDRESS = 2'd0;
    localparam logic [1:0] BYTE_CONTROL = 2'd1;
    localparam logic [1:0] BYTE_PAYLOAD = 2'd2;

    localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

// ===== src/oled_i2c_write_master_unit.sv =====
// Bit-level I2C write master for a small display controller. Each accepted
// submit transfer (tuser bit 0 set) starts one transaction: start condition,
// slave address byte, control byte (command or data, chosen by tuser bit 1),
// the payload byte and a stop condition. Every tick transfer (tuser bit 0
// clear) advances the bus by one delay phase; a bit takes three phases and
// the acknowledge is polled on tdata bit 8 once per tick. A missing
// acknowledge sets a sticky flag and the transaction goes on. Every input
// transfer yields exactly one result transfer with the bus levels and status
// after that step. The block takes one transfer per clock cycle: the state
// update and the result are one short combinational pass into the state and
// result registers, and the result register stalls the input only while a
// result waits and m_axis_tready is low.
module oled_i2c_write_master_unit (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [oled_i2c_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [oled_i2c_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // payload [7:0], sda_in [8], zeros [15:9]
    input  logic [oled_i2c_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // cmd [0], is_data [1]
    input  logic [oled_i2c_pkg::S_TUSER_W-1:0]  s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // scl [0], sda_level [1], sda_drive_enable [2], busy_res [3],
    // accepted [4], ack_missing [5], done_res [6], zero [7]
    output logic [oled_i2c_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    import oled_i2c_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_PEND = 4'd1,
        PH_ST1  = 4'd2,
        PH_ST2  = 4'd3,
        PH_ST3  = 4'd4,
        PH_BA   = 4'd5,
        PH_BB   = 4'd6,
        PH_BC   = 4'd7,
        PH_AH   = 4'd8,
        PH_AL   = 4'd9,
        PH_AG   = 4'd10,
        PH_SP1  = 4'd11
    } phase_t;

    logic [7:0] slave_address_reg;
    logic [7:0] command_ctrl_reg;
    logic [7:0] data_ctrl_reg;
    logic [7:0] ack_timeout_reg;

    phase_t     phase_reg, phase_next;
    logic [1:0] byte_num_reg, byte_num_next;
    logic [2:0] bit_num_reg, bit_num_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] held_payload_reg, held_payload_next;
    logic       held_kind_reg, held_kind_next;
    logic [7:0] poll_count_reg, poll_count_next;
    logic       missing_reg, missing_next;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic       s_fire;
    logic       in_submit;
    logic [7:0] in_payload;
    logic       in_is_data;
    logic       in_sda;
    logic       phase_is_idle;
    logic       do_load;
    logic [1:0] load_num;
    logic       accepted;
    logic       done;
    logic       scl;
    logic       sda;
    logic       sda_en;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign in_submit  = s_axis_tuser[0];
    assign in_is_data = s_axis_tuser[1];
    assign in_payload = s_axis_tdata[7:0];
    assign in_sda     = s_axis_tdata[8];

    assign phase_is_idle = (phase_reg == PH_IDLE) || (phase_reg > PH_SP1);

    always_comb begin
        phase_next        = phase_reg;
        byte_num_next     = byte_num_reg;
        bit_num_next      = bit_num_reg;
        shift_next        = shift_reg;
        held_payload_next = held_payload_reg;
        held_kind_next    = held_kind_reg;
        poll_count_next   = poll_count_reg;
        missing_next      = missing_reg;
        do_load           = 1'b0;
        load_num          = BYTE_ADDRESS;
        accepted          = 1'b0;
        done              = 1'b0;

        if (in_submit) begin
            if (phase_is_idle) begin
                held_payload_next = in_payload;
                held_kind_next    = in_is_data;
                missing_next      = 1'b0;
                byte_num_next     = BYTE_ADDRESS;
                bit_num_next      = 3'd0;
                poll_count_next   = 8'd0;
                phase_next        = PH_PEND;
                accepted          = 1'b1;
            end
        end else begin
            case (phase_reg)
                PH_PEND: phase_next = PH_ST1;
                PH_ST1:  phase_next = PH_ST2;
                PH_ST2:  phase_next = PH_ST3;
                PH_ST3: begin
                    do_load  = 1'b1;
                    load_num = BYTE_ADDRESS;
                end
                PH_BA:   phase_next = PH_BB;
                PH_BB:   phase_next = PH_BC;
                PH_BC: begin
                    if (bit_num_reg == LAST_BIT) begin
                        poll_count_next = 8'd0;
                        phase_next      = PH_AH;
                    end else begin
                        bit_num_next = bit_num_reg + 3'd1;
                        shift_next   = {shift_reg[6:0], 1'b0};
                        phase_next   = PH_BA;
                    end
                end
                PH_AH: begin
                    if (!in_sda) begin
                        phase_next = PH_AL;
                    end else if (poll_count_reg >= ack_timeout_reg) begin
                        missing_next = 1'b1;
                        phase_next   = PH_AG;
                    end else begin
                        poll_count_next = poll_count_reg + 8'd1;
                    end
                end
                PH_AL, PH_AG: begin
                    if (byte_num_reg >= BYTE_PAYLOAD) begin
                        phase_next = PH_SP1;
                    end else begin
                        do_load  = 1'b1;
                        load_num = byte_num_reg + 2'd1;
                    end
                end
                PH_SP1: begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                default: phase_next = PH_IDLE;
            endcase
        end

        if (do_load) begin
            byte_num_next = load_num;
            bit_num_next  = 3'd0;
            phase_next    = PH_BA;
            if (load_num == BYTE_ADDRESS) begin
                shift_next = slave_address_reg;
            end else if (load_num == BYTE_CONTROL) begin
                shift_next = held_kind_reg ? data_ctrl_reg : command_ctrl_reg;
            end else begin
                shift_next = held_payload_reg;
            end
        end

        scl    = 1'b1;
        sda    = 1'b1;
        sda_en = 1'b1;
        case (phase_next)
            PH_ST2: begin
                sda = 1'b0;
            end
            PH_ST3: begin
                scl = 1'b0;
                sda = 1'b0;
            end
            PH_BA, PH_BC: begin
                scl = 1'b0;
                sda = shift_next[7];
            end
            PH_BB: begin
                sda = shift_next[7];
            end
            PH_AH, PH_AG: begin
                sda_en = 1'b0;
            end
            PH_AL: begin
                scl    = 1'b0;
                sda_en = 1'b0;
            end
            PH_SP1: begin
                sda = 1'b0;
            end
            default: begin
                scl = 1'b1;
            end
        endcase

        m_data_next = {1'b0, done, missing_next, accepted,
                       (phase_next != PH_IDLE), sda_en, sda, scl};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= SLAVE_ADDRESS_RESET;
            command_ctrl_reg  <= COMMAND_CTRL_RESET;
            data_ctrl_reg     <= DATA_CTRL_RESET;
            ack_timeout_reg   <= ACK_TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_addr))
                CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_wdata;
                CFG_COMMAND_CTRL:  command_ctrl_reg  <= cfg_wdata;
                CFG_DATA_CTRL:     data_ctrl_reg     <= cfg_wdata;
                CFG_ACK_TIMEOUT:   ack_timeout_reg   <= cfg_wdata;
                default:           ack_timeout_reg   <= ack_timeout_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            byte_num_reg     <= 2'd0;
            bit_num_reg      <= 3'd0;
            shift_reg        <= 8'd0;
            held_payload_reg <= 8'd0;
            held_kind_reg    <= 1'b0;
            poll_count_reg   <= 8'd0;
            missing_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
        end else if (s_fire) begin
            phase_reg        <= phase_next;
            byte_num_reg     <= byte_num_next;
            bit_num_reg      <= bit_num_next;
            shift_reg        <= shift_next;
            held_payload_reg <= held_payload_next;
            held_kind_reg    <= held_kind_next;
            poll_count_reg   <= poll_count_next;
            missing_reg      <= missing_next;
            m_valid_reg      <= 1'b1;
            m_data_reg       <= m_data_next;
        end else if (m_axis_tready) begin
            m_valid_reg      <= 1'b0;
        end
    end

    a_reject_busy_submit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_submit && !phase_is_idle) |=> !m_data_reg[4])
        else $error("submit during a transaction was reported as accepted");

    a_idle_tick_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !in_submit && phase_reg == PH_IDLE) |=> (phase_reg == PH_IDLE))
        else $error("tick while idle left the idle phase");

    a_missing_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && missing_reg && !(in_submit && phase_is_idle)) |=> missing_reg)
        else $error("missing acknowledge flag cleared without a new transaction");

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (m_data_reg[3] == (phase_reg != PH_IDLE)))
        else $error("busy in the result disagrees with the sequencer phase");

endmodule

// ===== verif/oled_i2c_write_master_unit_tb.sv =====
`timescale 1ns / 100ps

module oled_i2c_write_master_unit_tb;

    import oled_i2c_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TOTAL_ITEMS = 550;
    localparam int RANDOM_SETTINGS = 4;

    typedef enum logic [3:0] {
        BUS_IDLE      = 4'd0,
        BUS_PENDING   = 4'd1,
        START_SETUP   = 4'd2,
        START_LOW_SDA = 4'd3,
        START_LOW_SCL = 4'd4,
        BIT_SETUP     = 4'd5,
        BIT_HIGH      = 4'd6,
        BIT_HOLD      = 4'd7,
        ACK_POLL      = 4'd8,
        ACK_TAKEN     = 4'd9,
        ACK_GIVEN_UP  = 4'd10,
        STOP_RELEASE  = 4'd11
    } bus_phase_t;

    typedef struct packed {
        logic spare;
        logic done;
        logic ack_missing;
        logic accepted;
        logic busy;
        logic sda_en;
        logic sda_level;
        logic scl;
    } bus_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_SLAVE_ADDRESS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // Register copies and sequencer state of the predictor.
    logic [7:0] cfg_slave_addr = SLAVE_ADDRESS_RESET;
    logic [7:0] cfg_cmd_ctrl   = COMMAND_CTRL_RESET;
    logic [7:0] cfg_data_ctrl  = DATA_CTRL_RESET;
    logic [7:0] cfg_ack_limit  = ACK_TIMEOUT_RESET;

    bus_phase_t bus_phase = BUS_IDLE;
    logic [1:0] byte_sel = BYTE_ADDRESS;
    logic [2:0] bit_sel = '0;
    logic [7:0] shifter = '0;
    logic [7:0] held_byte = '0;
    logic       held_data_kind = 1'b0;
    logic [7:0] polls = '0;
    logic       nack_seen = 1'b0;

    bus_result_t predicted_bus_q [$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          cycle_count = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    logic [31:0] stall_pattern = '1;

    string result_field [8] = '{"scl", "sda_level", "sda_drive_enable", "busy",
                                "accepted", "ack_missing", "done", "spare"};

    oled_i2c_write_master_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic void load_next_byte(input logic [1:0] which);
        byte_sel = which;
        if (which == BYTE_ADDRESS) begin
            shifter = cfg_slave_addr;
        end else if (which == BYTE_CONTROL) begin
            shifter = held_data_kind ? cfg_data_ctrl : cfg_cmd_ctrl;
        end else begin
            shifter = held_byte;
        end
        bit_sel = '0;
        bus_phase = BIT_SETUP;
    endfunction

    function automatic bus_result_t step_bus(input logic submit, input logic [7:0] pay,
                                             input logic kind, input logic sda_high);
        bus_result_t r;
        r = '0;
        r.scl = 1'b1;
        r.sda_level = 1'b1;
        r.sda_en = 1'b1;
        if (submit) begin
            if (bus_phase == BUS_IDLE) begin
                held_byte = pay;
                held_data_kind = kind;
                nack_seen = 1'b0;
                byte_sel = BYTE_ADDRESS;
                bit_sel = '0;
                polls = '0;
                bus_phase = BUS_PENDING;
                r.accepted = 1'b1;
            end
        end else begin
            case (bus_phase)
                BUS_PENDING:   bus_phase = START_SETUP;
                START_SETUP:   bus_phase = START_LOW_SDA;
                START_LOW_SDA: bus_phase = START_LOW_SCL;
                START_LOW_SCL: load_next_byte(BYTE_ADDRESS);
                BIT_SETUP:     bus_phase = BIT_HIGH;
                BIT_HIGH:      bus_phase = BIT_HOLD;
                BIT_HOLD: begin
                    if (bit_sel == LAST_BIT) begin
                        polls = '0;
                        bus_phase = ACK_POLL;
                    end else begin
                        bit_sel = bit_sel + 3'd1;
                        shifter = shifter << 1;
                        bus_phase = BIT_SETUP;
                    end
                end
                ACK_POLL: begin
                    if (!sda_high) begin
                        bus_phase = ACK_TAKEN;
                    end else if (polls >= cfg_ack_limit) begin
                        nack_seen = 1'b1;
                        bus_phase = ACK_GIVEN_UP;
                    end else begin
                        polls = polls + 8'd1;
                    end
                end
                ACK_TAKEN, ACK_GIVEN_UP: begin
                    if (byte_sel >= BYTE_PAYLOAD) begin
                        bus_phase = STOP_RELEASE;
                    end else begin
                        load_next_byte(byte_sel + 2'd1);
                    end
                end
                STOP_RELEASE: begin
                    bus_phase = BUS_IDLE;
                    r.done = 1'b1;
                end
                default: bus_phase = BUS_IDLE;
            endcase
        end
        case (bus_phase)
            START_LOW_SDA, STOP_RELEASE: begin
                r.scl = 1'b1;
                r.sda_level = 1'b0;
            end
            START_LOW_SCL: begin
                r.scl = 1'b0;
                r.sda_level = 1'b0;
            end
            BIT_SETUP, BIT_HOLD: begin
                r.scl = 1'b0;
                r.sda_level = shifter[7];
            end
            BIT_HIGH: begin
                r.scl = 1'b1;
                r.sda_level = shifter[7];
            end
            ACK_POLL, ACK_GIVEN_UP: begin
                r.scl = 1'b1;
                r.sda_en = 1'b0;
            end
            ACK_TAKEN: begin
                r.scl = 1'b0;
                r.sda_en = 1'b0;
            end
            default: ;
        endcase
        r.busy = (bus_phase != BUS_IDLE);
        r.ack_missing = nack_seen;
        return r;
    endfunction

    task automatic send_item(input logic submit, input logic [7:0] pay,
                             input logic kind, input logic sda_high);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 12);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, sda_high, pay};
        s_axis_tuser <= {kind, submit};
        do @(posedge aclk); while (!s_axis_tready);
        predicted_bus_q.push_back(step_bus(submit, pay, kind, sda_high));
        items_sent++;
    endtask

    task automatic write_registers(input logic [7:0] slave_addr, input logic [7:0] cmd_ctrl,
                                   input logic [7:0] data_ctrl, input logic [7:0] ack_limit);
        s_axis_tvalid <= 1'b0;
        while (predicted_bus_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_SLAVE_ADDRESS;
        cfg_wdata <= slave_addr;
        @(posedge aclk);
        cfg_addr <= CFG_COMMAND_CTRL;
        cfg_wdata <= cmd_ctrl;
        @(posedge aclk);
        cfg_addr <= CFG_DATA_CTRL;
        cfg_wdata <= data_ctrl;
        @(posedge aclk);
        cfg_addr <= CFG_ACK_TIMEOUT;
        cfg_wdata <= ack_limit;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_slave_addr = slave_addr;
        cfg_cmd_ctrl = cmd_ctrl;
        cfg_data_ctrl = data_ctrl;
        cfg_ack_limit = ack_limit;
    endtask

    // Starts a write when the bus is idle and ticks until it completes or
    // max_items transfers have gone. The first high_polls acknowledge polls
    // see SDA high, later ones see it low. Rejected submits are mixed in.
    task automatic drive_write(input logic [7:0] pay, input logic kind,
                               input int high_polls, input int max_items);
        int n;
        int polls_done;
        logic sda;
        n = 0;
        polls_done = 0;
        if (bus_phase == BUS_IDLE) begin
            send_item(1'b1, pay, kind, 1'($urandom_range(1)));
            n = 1;
        end
        while (bus_phase != BUS_IDLE && n < max_items) begin
            if ($urandom_range(29) == 0) begin
                send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end else begin
                if (bus_phase == ACK_POLL) begin
                    sda = (polls_done < high_polls);
                    polls_done++;
                end else begin
                    sda = 1'($urandom_range(1));
                end
                send_item(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)), sda);
            end
            n++;
        end
    endtask

    task automatic test_idle_and_default_write;
        repeat (4) send_item(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
        drive_write(8'h00, 1'b0, 0, 1000);
    endtask

    task automatic test_missing_ack_sticky;
        write_registers(8'hFF, 8'hFF, 8'h00, 8'd1);
        drive_write(8'hFF, 1'b1, 1000, 1000);
        repeat (3) send_item(1'b0, 8'h00, 1'b0, 1'b1);
        drive_write(8'h5A, 1'b0, 1, 1000);
    endtask

    task automatic test_long_timeout;
        write_registers(8'h00, 8'h00, 8'hFF, 8'd255);
        drive_write(8'h80, 1'b1, 2, 2000);
    endtask

    task automatic test_submit_while_busy;
        write_registers(SLAVE_ADDRESS_RESET, COMMAND_CTRL_RESET, DATA_CTRL_RESET, 8'd3);
        send_item(1'b1, 8'hC3, 1'b1, 1'b0);
        send_item(1'b1, 8'h3C, 1'b0, 1'b1);
        send_item(1'b0, 8'h00, 1'b0, 1'b0);
        send_item(1'b1, 8'hFF, 1'b1, 1'b0);
        drive_write(8'h00, 1'b0, 0, 1000);
    endtask

    task automatic test_config_mid_write;
        drive_write(8'hA5, 1'b1, 0, 30);
        write_registers(8'h3C, 8'h81, 8'h7E, 8'd2);
        drive_write(8'h00, 1'b0, 0, 1000);
    endtask

    task automatic test_random_writes;
        int high_polls;
        logic [7:0] ack_limit;
        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            if (s > 0 && items_sent >= TOTAL_ITEMS) begin
                break;
            end
            case (s)
                0: ack_limit = 8'($urandom_range(1, 4));
                1: ack_limit = 8'($urandom_range(2, 10));
                2: ack_limit = 8'd250;
                default: ack_limit = 8'd255;
            endcase
            write_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), ack_limit);
            if ($urandom_range(4) == 0) begin
                send_item(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
            if (ack_limit <= 10 && $urandom_range(2) == 0) begin
                high_polls = $urandom_range(0, 3 * (ack_limit + 1) + 2);
            end else begin
                high_polls = $urandom_range(0, 2);
            end
            drive_write(8'($urandom_range(255)), 1'($urandom_range(1)), high_polls, 4000);
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(3);
            stall_left = $urandom_range(20, 80);
            stall_pattern = $urandom;
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(1));
            2: begin
                m_axis_tready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
            end
            default: m_axis_tready <= ($urandom_range(7) != 0);
        endcase
    end

    always @(posedge aclk) begin : result_check
        bus_result_t want;
        bus_result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (predicted_bus_q.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = predicted_bus_q.pop_front();
                for (int i = 0; i < 8; i++) begin
                    if (want[i] !== got[i]) begin
                        $display("%0t: %s expected %b actual %b", $time, result_field[i],
                                 want[i], got[i]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_and_default_write;
        test_missing_ack_sticky;
        test_long_timeout;
        test_submit_while_busy;
        test_config_mid_write;
        test_random_writes;
        s_axis_tvalid <= 1'b0;
        while (predicted_bus_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== oled_i2c_write_master_unit.f =====
src/oled_i2c_pkg.sv
src/oled_i2c_write_master_unit.sv
verif/oled_i2c_write_master_unit_tb.sv
